### rtl/sha1sh_pkg.sv
package sha1sh_pkg;

	localparam logic [1:0] KIND_DATA       = 2'd0;
	localparam logic [1:0] KIND_FINAL_FULL = 2'd1;
	localparam logic [1:0] KIND_FINAL_PART = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] word;
		logic [2:0]  nbytes;
	} sha1sh_entry_t;

	typedef logic [4:0][31:0] sha1sh_digest_t;

	localparam sha1sh_digest_t INIT_DIGEST = {
		32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
	};

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

endpackage

### rtl/sha1sh_front.sv
module sha1sh_front
	import sha1sh_pkg::*;
(
	input  logic [31:0]   data_word,
	input  logic [2:0]    valid_bytes,
	input  logic          last_item,
	output sha1sh_entry_t entry
);

	logic [2:0]  count_clamped;
	logic [31:0] pad_word;

	assign count_clamped = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;

	always_comb begin
		unique case (count_clamped)
			3'd0:    pad_word = 32'h80000000;
			3'd1:    pad_word = {data_word[31:24], 24'h800000};
			3'd2:    pad_word = {data_word[31:16], 16'h8000};
			3'd3:    pad_word = {data_word[31:8], 8'h80};
			default: pad_word = data_word;
		endcase
	end

	always_comb begin
		if (!last_item) begin
			entry.kind   = KIND_DATA;
			entry.word   = data_word;
			entry.nbytes = 3'd4;
		end else if (count_clamped == 3'd4) begin
			entry.kind   = KIND_FINAL_FULL;
			entry.word   = data_word;
			entry.nbytes = 3'd4;
		end else begin
			entry.kind   = KIND_FINAL_PART;
			entry.word   = pad_word;
			entry.nbytes = count_clamped;
		end
	end

endmodule

### rtl/sha1sh_queue.sv
module sha1sh_queue
	import sha1sh_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  sha1sh_entry_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output sha1sh_entry_t rd_data,
	output logic          empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	sha1sh_entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/sha1sh_core.sv
module sha1sh_core
	import sha1sh_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  sha1sh_entry_t  entry,
	input  logic           entry_empty,
	output logic           entry_pop,
	input  logic           out_busy,
	output logic           digest_load,
	output sha1sh_digest_t digest
);

	localparam logic [2:0] ST_LOAD     = 3'd0;
	localparam logic [2:0] ST_PAD_MARK = 3'd1;
	localparam logic [2:0] ST_PAD_ZERO = 3'd2;
	localparam logic [2:0] ST_LEN_LO   = 3'd3;
	localparam logic [2:0] ST_ROUND    = 3'd4;
	localparam logic [2:0] ST_ADD      = 3'd5;
	localparam logic [2:0] ST_EMIT     = 3'd6;

	logic [2:0]     state_q, ret_q, nxt;
	logic [3:0]     fill_q;
	logic [63:0]    bits_q;
	logic [6:0]     rnd_q;
	sha1sh_digest_t chain_q;
	logic [31:0]    sched_q [16];
	logic [31:0]    a_q, b_q, c_q, d_q, e_q;

	logic        push_en;
	logic [31:0] push_word;
	logic [31:0] w_cur, w_new, f, k, t;

	assign w_cur = sched_q[0];
	assign w_new = {sched_q[13][30:0] ^ sched_q[8][30:0] ^ sched_q[2][30:0] ^ sched_q[0][30:0],
			sched_q[13][31] ^ sched_q[8][31] ^ sched_q[2][31] ^ sched_q[0][31]};

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
	end

	assign t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_cur;

	always_comb begin
		push_en     = 1'b0;
		push_word   = '0;
		entry_pop   = 1'b0;
		digest_load = 1'b0;
		nxt         = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (!entry_empty) begin
					entry_pop = 1'b1;
					push_en   = 1'b1;
					push_word = entry.word;
					case (entry.kind)
						KIND_DATA:       nxt = ST_LOAD;
						KIND_FINAL_FULL: nxt = ST_PAD_MARK;
						default:         nxt = ST_PAD_ZERO;
					endcase
				end
			end
			ST_PAD_MARK: begin
				push_en   = 1'b1;
				push_word = 32'h80000000;
				nxt       = ST_PAD_ZERO;
			end
			ST_PAD_ZERO: begin
				push_en = 1'b1;
				if (fill_q == 4'd14) begin
					push_word = bits_q[63:32];
					nxt       = ST_LEN_LO;
				end
			end
			ST_LEN_LO: begin
				push_en   = 1'b1;
				push_word = bits_q[31:0];
				nxt       = ST_EMIT;
			end
			ST_ROUND: begin
				nxt = (rnd_q == 7'd79) ? ST_ADD : ST_ROUND;
			end
			ST_ADD: begin
				nxt = ret_q;
			end
			ST_EMIT: begin
				if (!out_busy) begin
					digest_load = 1'b1;
					nxt         = ST_LOAD;
				end
			end
			default: nxt = ST_LOAD;
		endcase
	end

	assign digest = chain_q;

	always_ff @(posedge clk) begin
		if (push_en || state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[15] <= push_en ? push_word : w_new;
		end
		if (push_en && fill_q == 4'hf) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == ST_ROUND) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			ret_q   <= ST_LOAD;
			fill_q  <= '0;
			bits_q  <= '0;
			rnd_q   <= '0;
			chain_q <= INIT_DIGEST;
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 1'b1;
			end
			if (push_en && fill_q == 4'hf) begin
				state_q <= ST_ROUND;
				ret_q   <= nxt;
				rnd_q   <= '0;
			end else begin
				state_q <= nxt;
			end
			if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (entry_pop) begin
				bits_q <= bits_q + {58'd0, entry.nbytes, 3'b000};
			end
			if (state_q == ST_ADD) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			if (digest_load) begin
				chain_q <= INIT_DIGEST;
				bits_q  <= '0;
			end
		end
	end

endmodule

### rtl/sha1sh_digest_out.sv
module sha1sh_digest_out
	import sha1sh_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  sha1sh_digest_t digest,
	output logic           busy,
	input  logic           pop,
	output logic           empty,
	output logic [31:0]    digest_word,
	output logic [2:0]     word_index,
	output logic           last_word
);

	sha1sh_digest_t dig_q;
	logic [2:0]     idx_q;
	logic           valid_q;

	assign busy        = valid_q;
	assign empty       = !valid_q;
	assign digest_word = dig_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd4);

	always_ff @(posedge clk) begin
		if (load) begin
			dig_q <= digest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (pop && valid_q) begin
			if (idx_q == 3'd4) begin
				valid_q <= 1'b0;
				idx_q   <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

### rtl/sha1_stream_hasher.sv
// SHA-1 over a stream of big-endian 32-bit words.
// Input queue: drive data_word, valid_bytes and last_item with push; a
// transaction completes when push is high and full is low. Every word but
// the final one carries four bytes; the final word carries 0 to 4.
// Output queue: while empty is low the next digest word, its word_index
// and last_word are valid; pop takes it. Five transactions follow each
// message, H0 first, last_word high on the fifth.
// Words wait in a small input queue; while the engine is taking words and
// the queue is not empty, it loads one word a cycle into the block
// schedule. Each full block takes 80 rounds, one per cycle, plus the
// chaining update, and no words are loaded while a block is hashed.
// After the final word is accepted, the engine adds the padding and the
// length words, which may need an extra block, hashes them and then
// offers the first digest word.
// A stalled output holds the digest; the engine then waits before emitting
// the next digest, and the input queue fills and raises full.
// Reset clears the queues and returns the chaining words to the initial
// values; no message is in flight afterwards.
module sha1_stream_hasher
	import sha1sh_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last_item,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha1sh_entry_t  in_entry, q_entry;
	logic           q_empty, q_pop;
	logic           out_busy, digest_load;
	sha1sh_digest_t digest;

	sha1sh_front u_front (
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.last_item   (last_item),
		.entry       (in_entry)
	);

	sha1sh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (in_entry),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_entry),
		.empty   (q_empty)
	);

	sha1sh_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (q_entry),
		.entry_empty (q_empty),
		.entry_pop   (q_pop),
		.out_busy    (out_busy),
		.digest_load (digest_load),
		.digest      (digest)
	);

	sha1sh_digest_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (digest_load),
		.digest      (digest),
		.busy        (out_busy),
		.pop         (pop),
		.empty       (empty),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule

### sim/tb_sha1_stream_hasher.sv
module tb_sha1_stream_hasher;
	import sha1sh_pkg::*;

	localparam int RANDOM_ITEMS    = 200;
	localparam int CALM_ITEMS      = 30;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 250;
	localparam int WATCHDOG_LIMIT  = 4000;

	typedef struct {
		bit [31:0] word;
		bit [2:0]  pos;
		bit        lastw;
	} digest_rec_t;

	class sha1_scoreboard;
		bit [31:0]   chain[5];
		bit [31:0]   blk_words[16];
		bit [3:0]    fill;
		bit [63:0]   msg_bits;
		digest_rec_t expected_digests[$];
		int          errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			for (int i = 0; i < 5; i++)
				chain[i] = INIT_DIGEST[i];
			fill = '0;
			msg_bits = '0;
		endfunction

		function bit [31:0] rotl(bit [31:0] x, int s);
			return (x << s) | (x >> (32 - s));
		endfunction

		function void compress();
			bit [31:0] w[80];
			bit [31:0] a, b, c, d, e, f, k, t;
			for (int i = 0; i < 16; i++)
				w[i] = blk_words[i];
			for (int i = 16; i < 80; i++)
				w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (int i = 0; i < 80; i++) begin
				if (i < 20) begin
					f = (b & c) | (~b & d);
					k = K0;
				end else if (i < 40) begin
					f = b ^ c ^ d;
					k = K1;
				end else if (i < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = K2;
				end else begin
					f = b ^ c ^ d;
					k = K3;
				end
				t = rotl(a, 5) + f + e + k + w[i];
				e = d;
				d = c;
				c = rotl(b, 30);
				b = a;
				a = t;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		function void absorb(bit [31:0] word);
			blk_words[fill] = word;
			fill++;
			if (fill == 0)
				compress();
		endfunction

		function void note_input(bit [31:0] word, bit [2:0] count, bit lst);
			int unsigned cnt;
			bit [31:0]   mask;
			bit [31:0]   pad;
			digest_rec_t rec;
			if (!lst) begin
				msg_bits += 64'd32;
				absorb(word);
				return;
			end
			cnt = (count > 4) ? 4 : count;
			msg_bits += 64'(8 * cnt);
			if (cnt == 4) begin
				absorb(word);
				pad = 32'h8000_0000;
			end else begin
				mask = (cnt == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * cnt));
				pad = (word & mask) | (32'h80 << (24 - 8 * cnt));
			end
			absorb(pad);
			if (fill > 14)
				absorb(32'h0);
			while (fill < 14)
				absorb(32'h0);
			absorb(msg_bits[63:32]);
			absorb(msg_bits[31:0]);
			for (int j = 0; j < 5; j++) begin
				rec.word = chain[j];
				rec.pos = 3'(j);
				rec.lastw = (j == 4);
				expected_digests.push_back(rec);
			end
			restart();
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_result(bit [31:0] word, bit [2:0] pos, bit lastw);
			digest_rec_t rec;
			if (expected_digests.size() == 0) begin
				report_mismatch($sformatf("unexpected digest word %08h index %0d", word, pos));
				return;
			end
			rec = expected_digests.pop_front();
			if (word !== rec.word)
				report_mismatch($sformatf("digest_word %08h, want %08h (index %0d)",
					word, rec.word, rec.pos));
			if (pos !== rec.pos)
				report_mismatch($sformatf("word_index %0d, want %0d", pos, rec.pos));
			if (lastw !== rec.lastw)
				report_mismatch($sformatf("last_word %0b, want %0b (index %0d)",
					lastw, rec.lastw, rec.pos));
		endtask

		function int pending();
			return expected_digests.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [31:0] data_word;
	logic [2:0]  valid_bytes;
	logic        last_item;
	logic        empty;
	logic        pop;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha1_scoreboard sb = new();
	bit calm;
	int items_sent;
	int sender_idle_pct;
	int stall_cycles;

	sha1_stream_hasher i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.last_item   (last_item),
		.empty       (empty),
		.pop         (pop),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_item(input bit [31:0] w, input bit [2:0] cnt, input bit lst);
		int gap;
		@(negedge clk);
		push = 1'b1;
		data_word = w;
		valid_bytes = cnt;
		last_item = lst;
		do @(posedge clk); while (full);
		sb.note_input(w, cnt, lst);
		items_sent++;
		if (!calm && $urandom_range(0, 99) < sender_idle_pct) begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			push = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic bit [31:0] pick_word(int data_mode);
		case (data_mode)
			1: return 32'h0;
			2: return 32'hffff_ffff;
			default: begin
				case ($urandom_range(0, 9))
					0: return 32'h0;
					1: return 32'hffff_ffff;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	task automatic send_message(input int n_full, input bit [2:0] fin_cnt, input int data_mode);
		for (int i = 0; i < n_full; i++)
			send_item(pick_word(data_mode), 3'($urandom_range(0, 7)), 1'b0);
		send_item(pick_word(data_mode), fin_cnt, 1'b1);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		push = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int r;
		int n;
		int msg_count;
		arst_n = 1'b0;
		push = 1'b0;
		data_word = '0;
		valid_bytes = '0;
		last_item = 1'b0;
		calm = 1'b0;
		items_sent = 0;
		sender_idle_pct = 20;
		msg_count = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_message(0, 3'd0, 1);
		send_message(0, 3'd1, 2);
		send_message(0, 3'd2, 0);
		send_message(0, 3'd3, 2);
		send_message(0, 3'd4, 1);
		send_message(0, 3'd7, 2);
		send_item(32'hffff_ffff, 3'd0, 1'b0);
		send_item(32'h0, 3'd6, 1'b1);
		send_message(14, 3'd4, 0);
		wait_drained();

		while (items_sent < 23 + RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			if (r < 5)
				n = $urandom_range(0, 6);
			else if (r < 8)
				n = $urandom_range(12, 17);
			else if (r < 9)
				n = $urandom_range(28, 33);
			else
				n = $urandom_range(0, 40);
			sender_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
			if (items_sent >= 23 + RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			send_message(n, 3'($urandom_range(0, 7)), 0);
			msg_count++;
			if (msg_count == 8)
				wait_drained();
		end
		calm = 1'b1;
		@(negedge clk);
		push = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d digest words never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("tb_sha1_stream_hasher: done, clean");
		else
			$display("tb_sha1_stream_hasher: done, errors");
		$finish;
	end

	initial begin
		int idle;
		int seen;
		int recv_idle_pct;
		int cyc;
		bit held;
		idle = 0;
		seen = 0;
		recv_idle_pct = 20;
		cyc = 0;
		held = 1'b0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && seen >= 20) begin
				held = 1'b1;
				@(negedge clk);
				pop = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			cyc++;
			if (cyc % 64 == 0)
				recv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
			@(negedge clk);
			if (calm) begin
				idle = 0;
				pop = 1'b1;
			end else if (idle > 0) begin
				pop = 1'b0;
				idle--;
			end else if ($urandom_range(0, 99) < recv_idle_pct) begin
				idle = $urandom_range(1, 10) - 1;
				pop = 1'b0;
			end else begin
				pop = 1'b1;
			end
			@(posedge clk);
			if (pop && !empty) begin
				sb.check_result(digest_word, word_index, last_word);
				seen++;
			end
		end
	end

	initial stall_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles <= 0;
			end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("tb_sha1_stream_hasher: done, errors");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

endmodule
